// ===== rtl/core/dqie_pkg.sv =====
// dqie_pkg: shared types and constants for the deque with indexed erase
// command codes, controller state type, control and status bundles
// no dependencies

package dqie_pkg;

  // default number of list entries
  localparam int unsigned DQ_DEPTH = 16;

  // field widths fixed by the interface
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned DATA_W = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOVE,
    ST_PUT,
    ST_LSTART,
    ST_LIST
  } dq_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture incoming item
    logic dec;         // erase accepted: count minus one
    logic mv_start;    // first read of an entry shift
    logic mv_step;     // write one shifted entry, read the next
    logic put;         // write operand into the list, count plus one
    logic list_start;  // first read of a listing
    logic list_dir;    // direction for list_start
    logic list_next;   // advance listing position
  } dq_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             pos_ok;    // erase position inside the list
    logic             pos_tail;  // erase position is the back entry
    logic             mv_last;   // current shift step is the final one
    logic             eol;       // current listing item ends its direction
    logic             dir;       // current listing direction
  } dq_sts_t;

endpackage

// ===== rtl/core/dqie_ctrl.sv =====
// dqie_ctrl: sequencing state machine for the deque
// drives datapath commands and the channel handshakes
// depends on dqie_pkg

module dqie_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  dqie_pkg::dq_sts_t sts,
  output dqie_pkg::dq_ctl_t ctl
);

  dqie_pkg::dq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqie_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dqie_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = dqie_pkg::ST_DECODE;
      end
      dqie_pkg::ST_DECODE: begin
        if (sts.cmd inside {dqie_pkg::CMD_PUSH_FRONT, dqie_pkg::CMD_PUSH_BACK}) begin
          if (sts.full) begin
            state_nxt = dqie_pkg::ST_LSTART;
          end else if (sts.cmd == dqie_pkg::CMD_PUSH_FRONT && !sts.empty) begin
            state_nxt = dqie_pkg::ST_MOVE;
          end else begin
            state_nxt = dqie_pkg::ST_PUT;
          end
        end else if (sts.cmd == dqie_pkg::CMD_ERASE) begin
          if (sts.pos_ok && !sts.pos_tail) state_nxt = dqie_pkg::ST_MOVE;
          else                             state_nxt = dqie_pkg::ST_LSTART;
        end else begin
          state_nxt = dqie_pkg::ST_IDLE;
        end
      end
      dqie_pkg::ST_MOVE: begin
        if (sts.mv_last) begin
          state_nxt = (sts.cmd == dqie_pkg::CMD_PUSH_FRONT) ? dqie_pkg::ST_PUT
                                                             : dqie_pkg::ST_LSTART;
        end
      end
      dqie_pkg::ST_PUT:    state_nxt = dqie_pkg::ST_LSTART;
      dqie_pkg::ST_LSTART: state_nxt = dqie_pkg::ST_LIST;
      dqie_pkg::ST_LIST: begin
        if (out_ready && sts.eol && sts.dir) state_nxt = dqie_pkg::ST_IDLE;
      end
      default: state_nxt = dqie_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      dqie_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      dqie_pkg::ST_DECODE: begin
        if (sts.cmd == dqie_pkg::CMD_PUSH_FRONT) begin
          ctl.mv_start = !sts.full && !sts.empty;
        end else if (sts.cmd == dqie_pkg::CMD_ERASE) begin
          ctl.dec      = sts.pos_ok;
          ctl.mv_start = sts.pos_ok && !sts.pos_tail;
        end
      end
      dqie_pkg::ST_MOVE:   ctl.mv_step = 1'b1;
      dqie_pkg::ST_PUT:    ctl.put = 1'b1;
      dqie_pkg::ST_LSTART: ctl.list_start = 1'b1;
      dqie_pkg::ST_LIST: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (!sts.eol) begin
            ctl.list_next = 1'b1;
          end else if (!sts.dir) begin
            ctl.list_start = 1'b1;
            ctl.list_dir   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/dqie_dpath.sv =====
// dqie_dpath: entry memory, count, position counter and result fields
// executes the commands issued by dqie_ctrl
// depends on dqie_pkg

module dqie_dpath #(
  parameter int unsigned DEPTH = dqie_pkg::DQ_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [dqie_pkg::CMD_W-1:0]        in_cmd,
  input  logic signed [dqie_pkg::DATA_W-1:0] in_operand,
  input  dqie_pkg::dq_ctl_t                 ctl,
  output dqie_pkg::dq_sts_t                 sts,
  output logic                              out_direction,
  output logic signed [dqie_pkg::DATA_W-1:0] out_element,
  output logic                              out_has_element,
  output logic                              out_end_of_listing,
  output logic                              out_last,
  output logic                              out_dropped
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = dqie_pkg::DATA_W;

  logic signed [DW-1:0] mem [DEPTH];
  logic signed [DW-1:0] rd_data_r;

  logic [dqie_pkg::CMD_W-1:0] cmd_r;
  logic [DW-1:0]              op_r;
  logic                       drop_r;
  logic                       dir_r, dir_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;

  logic          rd_en, we;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] wr_data;
  logic [CW:0]   idx_x, cnt_x;
  logic [AW-1:0] cnt_m1, pos_a;
  logic          is_front;

  assign idx_x    = (CW+1)'(idx_r);
  assign cnt_x    = (CW+1)'(count_r);
  assign cnt_m1   = AW'(count_r - CW'(1));
  assign pos_a    = op_r[AW-1:0];
  assign is_front = (cmd_r == dqie_pkg::CMD_PUSH_FRONT);

  // status towards the controller
  always_comb begin
    sts.cmd      = cmd_r;
    sts.full     = (cnt_x >= (CW+1)'(DEPTH));
    sts.empty    = (count_r == '0);
    sts.pos_ok   = !op_r[DW-1] && (op_r < DW'(count_r));
    sts.pos_tail = ((op_r + DW'(1)) == DW'(count_r));
    sts.mv_last  = is_front ? (idx_r == AW'(1)) : ((idx_x + (CW+1)'(1)) == cnt_x);
    sts.eol      = (count_r == '0) ||
                   (dir_r ? (idx_r == '0) : ((idx_x + (CW+1)'(1)) == cnt_x));
    sts.dir      = dir_r;
  end

  // read, write and counter updates
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    we        = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rd_data_r;
    idx_nxt   = idx_r;
    dir_nxt   = dir_r;
    count_nxt = count_r;
    if (ctl.dec) begin
      count_nxt = count_r - CW'(1);
    end
    if (ctl.mv_start) begin
      rd_en = 1'b1;
      if (is_front) begin
        rd_addr = cnt_m1;
        idx_nxt = AW'(count_r);
      end else begin
        rd_addr = AW'(pos_a + AW'(1));
        idx_nxt = pos_a;
      end
    end
    if (ctl.mv_step) begin
      we    = 1'b1;
      rd_en = !sts.mv_last;
      if (is_front) begin
        rd_addr = AW'(idx_r - AW'(2));
        idx_nxt = AW'(idx_r - AW'(1));
      end else begin
        rd_addr = AW'(idx_x + (CW+1)'(2));
        idx_nxt = AW'(idx_x + (CW+1)'(1));
      end
    end
    if (ctl.put) begin
      we        = 1'b1;
      wr_addr   = is_front ? '0 : AW'(count_r);
      wr_data   = op_r;
      count_nxt = count_r + CW'(1);
    end
    if (ctl.list_start) begin
      rd_en   = 1'b1;
      dir_nxt = ctl.list_dir;
      rd_addr = (ctl.list_dir && count_r != '0) ? cnt_m1 : '0;
      idx_nxt = rd_addr;
    end
    if (ctl.list_next) begin
      rd_en   = 1'b1;
      rd_addr = dir_r ? AW'(idx_r - AW'(1)) : AW'(idx_r + AW'(1));
      idx_nxt = rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      dir_r   <= 1'b0;
      cmd_r   <= dqie_pkg::CMD_UNUSED;
      drop_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      dir_r   <= dir_nxt;
      if (ctl.load) begin
        cmd_r  <= in_cmd;
        drop_r <= (in_cmd == dqie_pkg::CMD_PUSH_FRONT || in_cmd == dqie_pkg::CMD_PUSH_BACK)
                  && (cnt_x >= (CW+1)'(DEPTH));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) op_r <= in_operand;
  end

  assign out_direction      = dir_r;
  assign out_has_element    = (count_r != '0);
  assign out_element        = out_has_element ? rd_data_r : '0;
  assign out_end_of_listing = sts.eol;
  assign out_last           = sts.eol && dir_r;
  assign out_dropped        = drop_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_x <= (CW+1)'(DEPTH))
    else $error("entry count above depth");

  a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.put |-> cnt_x < (CW+1)'(DEPTH))
    else $error("write into a full list");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.dec |-> count_r != '0)
    else $error("erase from an empty list");

  a_count_steady_listing: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.list_next |=> $stable(count_r))
    else $error("count changed during listing");
`endif

endmodule

// ===== rtl/core/deque_with_indexed_erase_top.sv =====
// deque_with_indexed_erase_top: ordered list with push front, push back and erase
// joins dqie_ctrl (sequencing) and dqie_dpath (memory and fields)
// depends on dqie_pkg, dqie_ctrl, dqie_dpath
//
//   channel | direction | fields
//   --------+-----------+------------------------------------------------------
//   in_     | input     | cmd, operand
//   out_    | output    | direction, element, has_element, end_of_listing,
//           |           | last, dropped
//
// one item at a time, count taken before the command: accept, decode, then an entry
// shift (push front onto a non-empty list, or erase short of the back entry), a write
// for a push, listing start, then every entry front to back and back to front (one empty item each way if empty)
// one write a cycle paces the shift
// rst_n (synchronous) clears count and the controller; entries need no clearing
// a stalled result holds in the memory read register until taken

module deque_with_indexed_erase_top #(
  parameter int unsigned DEPTH = dqie_pkg::DQ_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dqie_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [dqie_pkg::DATA_W-1:0] in_operand,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_direction,
  output logic signed [dqie_pkg::DATA_W-1:0] out_element,
  output logic                               out_has_element,
  output logic                               out_end_of_listing,
  output logic                               out_last,
  output logic                               out_dropped
);

  dqie_pkg::dq_ctl_t ctl;
  dqie_pkg::dq_sts_t sts;

  // state machine: handshakes and per-cycle commands
  dqie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // entry store, count and result fields
  dqie_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_cmd),
    .in_operand         (in_operand),
    .ctl                (ctl),
    .sts                (sts),
    .out_direction      (out_direction),
    .out_element        (out_element),
    .out_has_element    (out_has_element),
    .out_end_of_listing (out_end_of_listing),
    .out_last           (out_last),
    .out_dropped        (out_dropped)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("item accepted while a listing is open");

  a_last_ends_listing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> out_end_of_listing && out_direction)
    else $error("last item outside the reverse listing end");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("block not idle after final item");
`endif

endmodule

// ===== verif/dqie_listing_checker.sv =====
`timescale 1ns / 1ps
// dqie_listing_checker: keeps a shadow of the deque, predicts every listing item and
// compares what the block returns; depends on dqie_pkg

module dqie_listing_checker
  import dqie_pkg::*;
#(
  parameter int unsigned DEPTH = DQ_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [CMD_W-1:0]          in_cmd,
  input  logic signed [DATA_W-1:0]  in_operand,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      out_direction,
  input  logic signed [DATA_W-1:0]  out_element,
  input  logic                      out_has_element,
  input  logic                      out_end_of_listing,
  input  logic                      out_last,
  input  logic                      out_dropped,
  output int                        mismatches,
  output int                        outstanding,
  output int                        compared
);

  typedef struct packed {
    logic                     dir;
    logic signed [DATA_W-1:0] elem;
    logic                     has;
    logic                     eol;
    logic                     fin;
    logic                     drop;
  } listing_item_t;

  logic signed [DATA_W-1:0] shadow [DEPTH];
  int                       shadow_len;
  listing_item_t            listing_q [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    compared    = 0;
    shadow_len  = 0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  // add one predicted item at the tail of the expected queue
  task automatic enqueue_expected(input listing_item_t it);
    listing_q.insert(listing_q.size(), it);
  endtask

  // update the shadow list and queue both listings that the command causes
  task automatic apply_command(input logic [CMD_W-1:0] c,
                               input logic signed [DATA_W-1:0] v);
    logic          refused;
    int            idx;
    int            pass;
    listing_item_t it;
    refused = 1'b0;
    if (c != CMD_UNUSED) begin
      case (c)
        CMD_PUSH_FRONT: begin
          if (shadow_len >= DEPTH) begin
            refused = 1'b1;
          end else begin
            for (idx = shadow_len; idx > 0; idx--) shadow[idx] = shadow[idx-1];
            shadow[0] = v;
            shadow_len++;
          end
        end
        CMD_PUSH_BACK: begin
          if (shadow_len >= DEPTH) begin
            refused = 1'b1;
          end else begin
            shadow[shadow_len] = v;
            shadow_len++;
          end
        end
        default: begin
          // out of range positions leave the list as it is
          if (v >= 0 && v < shadow_len) begin
            for (idx = v; idx < shadow_len - 1; idx++) shadow[idx] = shadow[idx+1];
            shadow_len--;
          end
        end
      endcase
      for (pass = 0; pass < 2; pass++) begin
        if (shadow_len == 0) begin
          it.dir  = pass[0];
          it.elem = '0;
          it.has  = 1'b0;
          it.eol  = 1'b1;
          it.fin  = (pass == 1);
          it.drop = refused;
          enqueue_expected(it);
        end else begin
          for (idx = 0; idx < shadow_len; idx++) begin
            it.dir  = pass[0];
            it.elem = (pass == 0) ? shadow[idx] : shadow[shadow_len-1-idx];
            it.has  = 1'b1;
            it.eol  = (idx == shadow_len - 1);
            it.fin  = it.eol && (pass == 1);
            it.drop = refused;
            enqueue_expected(it);
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch_channels
    listing_item_t want;
    if (!rst_n) begin
      shadow_len = 0;
      listing_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        apply_command(in_cmd, in_operand);
      end
      if (out_valid && out_ready) begin
        compared++;
        if (listing_q.size() == 0) begin
          report_mismatch($sformatf("unexpected listing item, element %0d", out_element));
        end else begin
          want = listing_q.pop_front();
          if (out_direction !== want.dir)
            report_mismatch($sformatf("direction %b, wanted %b", out_direction, want.dir));
          // an empty listing carries a zero element
          if (out_element !== want.elem)
            report_mismatch($sformatf("element %0d, wanted %0d", out_element, want.elem));
          if (out_has_element !== want.has)
            report_mismatch($sformatf("has_element %b, wanted %b", out_has_element, want.has));
          if (out_end_of_listing !== want.eol)
            report_mismatch($sformatf("end_of_listing %b, wanted %b",
                                      out_end_of_listing, want.eol));
          if (out_last !== want.fin)
            report_mismatch($sformatf("last %b, wanted %b", out_last, want.fin));
          if (out_dropped !== want.drop)
            report_mismatch($sformatf("dropped %b, wanted %b", out_dropped, want.drop));
        end
      end
    end
    outstanding <= listing_q.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// tb: stimulus and verdict for deque_with_indexed_erase_top
// depends on dqie_pkg, the block itself and dqie_listing_checker

module tb;
  import dqie_pkg::*;

  localparam int unsigned DEPTH        = DQ_DEPTH;
  localparam int          RANDOM_ITEMS = 410;
  // cycles with no item moving on either channel before the run is called hung
  localparam int          STALL_LIMIT  = 2000;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic [CMD_W-1:0]         in_cmd     = CMD_PUSH_FRONT;
  logic signed [DATA_W-1:0] in_operand = '0;
  logic                     out_ready  = 1'b0;

  logic                     in_ready;
  logic                     out_valid;
  logic                     out_direction;
  logic signed [DATA_W-1:0] out_element;
  logic                     out_has_element;
  logic                     out_end_of_listing;
  logic                     out_last;
  logic                     out_dropped;

  int mismatches;
  int outstanding;
  int compared;

  // set during a stretch where neither side idles
  bit steady       = 1'b0;
  int stall_cycles = 0;
  int n_push       = 0;
  int n_erase      = 0;
  int n_unused     = 0;

  deque_with_indexed_erase_top #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_operand         (in_operand),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_direction      (out_direction),
    .out_element        (out_element),
    .out_has_element    (out_has_element),
    .out_end_of_listing (out_end_of_listing),
    .out_last           (out_last),
    .out_dropped        (out_dropped)
  );

  dqie_listing_checker #(
    .DEPTH(DEPTH)
  ) listing_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_operand         (in_operand),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_direction      (out_direction),
    .out_element        (out_element),
    .out_has_element    (out_has_element),
    .out_end_of_listing (out_end_of_listing),
    .out_last           (out_last),
    .out_dropped        (out_dropped),
    .mismatches         (mismatches),
    .outstanding        (outstanding),
    .compared           (compared)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver back-pressure: low about 18 percent of the time, never while steady
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 18);
    end
  end

  // hang detection: counts cycles in which no item moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, outstanding);
      $display("Some tests failed");
      $finish;
    end
  end

  // offer one item, with random idle cycles ahead of it, and hold until taken
  task automatic send_item(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v);
    while (!steady && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= c;
    in_operand <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: n_push++;
      CMD_ERASE:                     n_erase++;
      default:                       n_unused++;
    endcase
  endtask

  // hold off the sender until every predicted listing item has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int                       n;
    int                       r;
    int                       lim_front;
    int                       lim_back;
    logic [CMD_W-1:0]         c;
    logic signed [DATA_W-1:0] v;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: erase on an empty list, the unused code, extreme values,
    // and erase positions that are negative, at the count, huge, middle, tail, front
    send_item(CMD_ERASE, 0);
    send_item(CMD_UNUSED, 32'sh5a5a_a5a5);
    send_item(CMD_PUSH_FRONT, 32'sh7fff_ffff);
    send_item(CMD_PUSH_BACK, 32'sh8000_0000);
    send_item(CMD_PUSH_FRONT, -1);
    send_item(CMD_PUSH_BACK, 0);
    send_item(CMD_PUSH_FRONT, 1);
    send_item(CMD_ERASE, -1);
    send_item(CMD_ERASE, 5);
    send_item(CMD_ERASE, 32'sh7fff_ffff);
    send_item(CMD_ERASE, 32'sh8000_0000);
    send_item(CMD_ERASE, 2);
    send_item(CMD_ERASE, 3);
    send_item(CMD_ERASE, 0);
    send_item(CMD_UNUSED, -1);
    send_item(CMD_PUSH_BACK, 32'sh0f0f_f0f0);
    send_item(CMD_ERASE, 1);
    send_item(CMD_ERASE, 0);
    // one entry is left in the list here
    wait_drained();

    // random part in phases of 40 items: growing (reaches a full list and
    // refused pushes), mixed, and shrinking (back down to empty)
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / 40) % 3)
        0:       begin lim_front = 40; lim_back = 80; end
        1:       begin lim_front = 30; lim_back = 60; end
        default: begin lim_front = 15; lim_back = 30; end
      endcase
      r = $urandom_range(0, 99);
      if (r < lim_front)      c = CMD_PUSH_FRONT;
      else if (r < lim_back)  c = CMD_PUSH_BACK;
      else if (r < 97)        c = CMD_ERASE;
      else                    c = CMD_UNUSED;

      r = $urandom_range(0, 99);
      if (c == CMD_ERASE) begin
        // mostly positions around the live range, some negative, some huge
        if (r < 80)      v = $urandom_range(0, DEPTH + 1);
        else if (r < 90) v = $urandom | 32'h8000_0000;
        else             v = $urandom & 32'h7fff_ffff;
      end else begin
        if (r < 10)      v = 32'sh8000_0000;
        else if (r < 20) v = 32'sh7fff_ffff;
        else if (r < 25) v = 0;
        else if (r < 30) v = -1;
        else             v = $urandom;
      end

      // a stretch with no idling on either side
      steady = (n >= 160 && n < 240);
      if (n == 300) wait_drained();
      send_item(c, v);
    end
    steady = 1'b0;

    // drain, then allow a full-list turnaround for anything stray
    wait_drained();
    repeat (2 * DEPTH + 8) @(posedge clk);

    $display("%0d commands driven: %0d pushes, %0d erases, %0d unused codes",
             n_push + n_erase + n_unused, n_push, n_erase, n_unused);
    $display("%0d listing items compared, %0d mismatches", compared, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
